// ----- hw/rtl/mts_pkg.sv -----
// Package for the min-tracking stack: payload structs, opcodes, error codes,
// controller states and default sizes. No dependencies.
package mts_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int DATA_W          = 32;
   localparam int ENTRY_W         = 7;
   localparam int OP_W            = 2;
   localparam int ERR_W           = 2;

   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

   localparam logic signed [DATA_W-1:0] MIN_NONE = -32'sd1;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic signed [DATA_W-1:0] min_value;
      logic [ENTRY_W-1:0]       entry_count;
      logic                     is_empty;
      logic [ERR_W-1:0]         error_code;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic update;
      logic load_top;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

// ----- hw/rtl/mts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mts_ctrl.sv -----
// Controller for the min-tracking stack: sequences update, top refetch and
// result publish. Depends on mts_pkg.
module mts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mts_pkg::stat_type stat,
   output mts_pkg::cmd_type  cmd
);

   mts_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.update   = 1'b0;
      cmd.load_top = 1'b0;
      cmd.publish  = 1'b0;
      unique case (state_ff)
         mts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.update = 1'b1;
               state_in   = mts_pkg::ST_FETCH;
            end
         end
         mts_pkg::ST_FETCH: begin
            cmd.load_top = 1'b1;
            state_in     = mts_pkg::ST_PUBLISH;
         end
         mts_pkg::ST_PUBLISH: begin
            if (stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = mts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mts_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/mts_dp.sv -----
// Datapath for the min-tracking stack: counters, cached tops, both stores and
// the result register. Depends on mts_pkg and mts_ram.
module mts_dp #(
   parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  mts_pkg::cmd_type  cmd,
   output mts_pkg::stat_type stat,
   input  mts_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mts_pkg::rsp_type  rsp_data
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    mcount_ff, mcount_in;
   logic signed [mts_pkg::DATA_W-1:0] top_ff, top_in;
   logic signed [mts_pkg::DATA_W-1:0] mtop_ff, mtop_in;
   logic [mts_pkg::ERR_W-1:0]        err_ff, err_in;
   logic                             pop_ff, pop_in;
   mts_pkg::rsp_type                 rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]               mc_base;
   logic [CW-1:0]               mc_pop;
   logic                        v_we, m_we;
   logic [AW-1:0]               v_waddr, m_waddr, v_raddr, m_raddr;
   logic [mts_pkg::DATA_W-1:0]  v_rdata, m_rdata;

   mts_ram #(.WIDTH(mts_pkg::DATA_W), .DEPTH(STACK_DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (req_data.value),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   mts_ram #(.WIDTH(mts_pkg::DATA_W), .DEPTH(STACK_DEPTH)) u_min_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (req_data.value),
      .rd_addr (m_raddr),
      .rd_data (m_rdata)
   );

   always_comb begin
      count_in  = count_ff;
      mcount_in = mcount_ff;
      top_in    = top_ff;
      mtop_in   = mtop_ff;
      err_in    = err_ff;
      pop_in    = pop_ff;
      v_we      = 1'b0;
      m_we      = 1'b0;
      v_waddr   = count_ff[AW-1:0];
      mc_base   = (count_ff == '0) ? '0 : mcount_ff;
      m_waddr   = mc_base[AW-1:0];
      mc_pop    = (mcount_ff != '0 && top_ff == mtop_ff) ? mcount_ff - 1'b1 : mcount_ff;
      v_raddr   = '0;
      m_raddr   = '0;
      if (cmd.update) begin
         err_in = mts_pkg::ERR_OK;
         pop_in = 1'b0;
         priority if (req_data.opcode == mts_pkg::OP_PUSH) begin
            if (count_ff == FULL_COUNT) begin
               err_in = mts_pkg::ERR_FULL;
            end else begin
               mcount_in = mc_base;
               if ((mc_base == '0 || req_data.value <= mtop_ff) && mc_base < FULL_COUNT) begin
                  m_we      = 1'b1;
                  mcount_in = mc_base + 1'b1;
                  mtop_in   = req_data.value;
               end
               v_we     = 1'b1;
               count_in = count_ff + 1'b1;
               top_in   = req_data.value;
            end
         end else if (req_data.opcode == mts_pkg::OP_POP) begin
            if (count_ff == '0) begin
               err_in = mts_pkg::ERR_EMPTY;
            end else begin
               pop_in    = 1'b1;
               count_in  = count_ff - 1'b1;
               mcount_in = (count_in == '0) ? '0 : mc_pop;
               v_raddr   = AW'(count_in - 1'b1);
               m_raddr   = AW'(mcount_in - 1'b1);
            end
         end else begin
            err_in = mts_pkg::ERR_OK;
         end
      end
      if (cmd.load_top && pop_ff) begin
         top_in  = v_rdata;
         mtop_in = m_rdata;
      end
   end

   always_comb begin
      rsp_in.entry_count = mts_pkg::ENTRY_W'(count_ff);
      rsp_in.error_code  = err_ff;
      if (count_ff == '0) begin
         rsp_in.top_value = '0;
         rsp_in.min_value = mts_pkg::MIN_NONE;
         rsp_in.is_empty  = 1'b1;
      end else begin
         rsp_in.top_value = top_ff;
         rsp_in.min_value = (mcount_ff != '0) ? mtop_ff : mts_pkg::MIN_NONE;
         rsp_in.is_empty  = 1'b0;
      end
      stat.out_free = !rsp_valid_ff || rsp_ready;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         mcount_ff    <= mcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff  <= top_in;
      mtop_ff <= mtop_in;
      err_ff  <= err_in;
      pop_ff  <= pop_in;
      if (cmd.publish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/min_tracking_stack_top.sv -----
// Min-tracking stack top level: one beat in, one result beat out per operation.
// Each operation steps through update, a registered read of the new tops from the
// value and minimum RAMs after a pop, and publish; a new request beat is taken
// only once the last result is published. Publish holds while an earlier
// result beat waits. Reset clears the counters, controller and result valid;
// the stores are not cleared and need no clearing pass.
// Depends on mts_pkg, mts_ctrl, mts_dp.
module min_tracking_stack_top #(
   parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mts_pkg::rsp_type rsp_data
);

   mts_pkg::cmd_type  cmd;
   mts_pkg::stat_type stat;

   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mts_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an operation is in flight");

   a_empty_pop_is_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error_code == mts_pkg::ERR_EMPTY) |-> rsp_data.is_empty)
      else $error("refused pop reported a non-empty stack");

   a_full_push_not_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error_code == mts_pkg::ERR_FULL) |-> !rsp_data.is_empty)
      else $error("refused push reported an empty stack");

   a_empty_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_empty) |->
         (rsp_data.top_value == '0 && rsp_data.min_value == mts_pkg::MIN_NONE))
      else $error("empty result carries stale top or minimum");

endmodule
